// ----- design/su2_pkg.sv -----
package su2_pkg;

    localparam int MAX_DIM_DEFAULT      = 1024;
    localparam int MAX_CHANNELS_DEFAULT = 16;

    localparam int DIM_REG_W  = 11;
    localparam int IN_IDX_W   = 10;
    localparam int OUT_IDX_W  = 11;
    localparam int CHAN_W     = 4;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 2;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    localparam logic [DIM_REG_W-1:0] DIM_RESET = 11'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 2'd1;

    // gain as a left shift: x4, x2 on one Nyquist line, x1 on the corner
    localparam logic [1:0] SHIFT_X4 = 2'd2;
    localparam logic [1:0] SHIFT_X2 = 2'd1;
    localparam logic [1:0] SHIFT_X1 = 2'd0;

    typedef struct packed {
        logic signed [VAL_W-1:0] im;
        logic signed [VAL_W-1:0] re;
        logic [CHAN_W-1:0]       chan;
        logic [IN_IDX_W-1:0]     col;
        logic [IN_IDX_W-1:0]     row;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] im;
        logic signed [VAL_W-1:0] re;
        logic [CHAN_W-1:0]       chan;
        logic [OUT_IDX_W-1:0]    col;
        logic [OUT_IDX_W-1:0]    row;
    } t_write;

    typedef struct packed {
        logic drop;  // item out of range, gives no writes
        logic last;  // current write is the final one of the item
    } t_map_stat;

    function automatic logic signed [VAL_W-1:0] sat_shift(
        input logic signed [VAL_W-1:0] v,
        input logic [1:0]              sh
    );
        logic signed [VAL_W+1:0] p;
        logic signed [VAL_W-1:0] res;
        p = (VAL_W + 2)'(v) <<< sh;
        if (p[VAL_W+1:VAL_W-1] == 3'b000 || p[VAL_W+1:VAL_W-1] == 3'b111) begin
            res = p[VAL_W-1:0];
        end else if (p[VAL_W+1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ----- design/su2_map.sv -----
module su2_map #(
    parameter int MAX_DIM      = su2_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_CHANNELS = su2_pkg::MAX_CHANNELS_DEFAULT
) (
    input  su2_pkg::t_item                   i_item,
    input  logic [1:0]                       i_k,
    input  logic [su2_pkg::DIM_REG_W-1:0]    i_width,
    input  logic [su2_pkg::DIM_REG_W-1:0]    i_height,
    output su2_pkg::t_write                  o_write,
    output su2_pkg::t_map_stat               o_stat
);

    localparam int DimBits = $clog2(MAX_DIM + 1);
    localparam int EffW    = (DimBits > su2_pkg::DIM_REG_W) ? DimBits : su2_pkg::DIM_REG_W;
    localparam int ChBits  = $clog2(MAX_CHANNELS + 1);
    localparam int ChW     = (ChBits > su2_pkg::CHAN_W) ? ChBits : su2_pkg::CHAN_W;
    localparam int DW      = su2_pkg::DIM_REG_W;

    logic [DW-1:0] eff_w, eff_h, half_w, half_h;
    logic [DW:0]   w_p1, h_p1;
    logic [DW-1:0] col_x, row_x, col_pos, row_pos;
    logic          nyq_c, nyq_r, col_sel, row_sel;
    logic [1:0]    shift;

    // 0 acts as 1, anything above the maximum acts as the maximum
    always_comb begin
        if (i_width == '0) begin
            eff_w = DW'(1);
        end else if (EffW'(i_width) > EffW'(MAX_DIM)) begin
            eff_w = DW'(MAX_DIM);
        end else begin
            eff_w = i_width;
        end
        if (i_height == '0) begin
            eff_h = DW'(1);
        end else if (EffW'(i_height) > EffW'(MAX_DIM)) begin
            eff_h = DW'(MAX_DIM);
        end else begin
            eff_h = i_height;
        end
    end

    assign w_p1   = {1'b0, eff_w} + (DW + 1)'(1);
    assign h_p1   = {1'b0, eff_h} + (DW + 1)'(1);
    assign half_w = w_p1[DW:1];
    assign half_h = h_p1[DW:1];

    assign col_x = DW'(i_item.col);
    assign row_x = DW'(i_item.row);

    assign nyq_c = !eff_w[0] && (col_x == half_w);
    assign nyq_r = !eff_h[0] && (row_x == half_h);

    assign col_pos = (col_x < half_w) ? col_x : col_x + eff_w;
    assign row_pos = (row_x < half_h) ? row_x : row_x + eff_h;

    // row-major order over the split positions
    assign col_sel = nyq_c && i_k[0];
    assign row_sel = nyq_r && (nyq_c ? i_k[1] : i_k[0]);

    always_comb begin
        if (nyq_c && nyq_r) begin
            shift = su2_pkg::SHIFT_X1;
        end else if (nyq_c || nyq_r) begin
            shift = su2_pkg::SHIFT_X2;
        end else begin
            shift = su2_pkg::SHIFT_X4;
        end
    end

    always_comb begin
        o_write.row  = nyq_r ? (row_sel ? half_h + eff_h : half_h) : row_pos;
        o_write.col  = nyq_c ? (col_sel ? half_w + eff_w : half_w) : col_pos;
        o_write.chan = i_item.chan;
        o_write.re   = su2_pkg::sat_shift(i_item.re, shift);
        o_write.im   = su2_pkg::sat_shift(i_item.im, shift);
    end

    assign o_stat.drop = (col_x >= eff_w) || (row_x >= eff_h)
                       || (ChW'(i_item.chan) >= ChW'(MAX_CHANNELS));
    assign o_stat.last = (i_k == {nyq_r && nyq_c, nyq_r || nyq_c});

endmodule

// ----- design/spectrum_upsample_by_two.sv -----
// Fourier-domain upsampling by two, one DFT coefficient per request.
//
// s_axis carries one coefficient: tdata = {im, re, chan, col, row}.
// m_axis carries write requests into the doubled plane; tlast marks the
// final write of a coefficient. Ordinary coefficients give one write,
// Nyquist rows or columns two, the Nyquist corner four. Out-of-range
// coefficients are dropped without any write.
// Config channel: index 0 = in_width, index 1 = in_height, written while idle.
//
// The input register holds each coefficient; its writes then pass the output register to m_axis.
// Throughput: one coefficient per cycle for single-write coefficients while m_axis is ready;
// a coefficient with several writes holds the input register until its last write enters the
// output register, one write per cycle leaving through the output register unless m_axis stalls.
// Reset (i_rst_n low, synchronous): both register stages empty, dimensions
// back to 256. When m_axis stalls the output register holds its write and the
// input register fills; s_axis_tready then falls until the write is taken.
module spectrum_upsample_by_two #(
    parameter int MAX_DIM      = su2_pkg::MAX_DIM_DEFAULT,
    parameter int MAX_CHANNELS = su2_pkg::MAX_CHANNELS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row[9:0], col[19:10], chan[23:20], re[55:24], im[87:56]
    input  logic [su2_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // row[10:0], col[21:11], chan[25:22], re[57:26], im[89:58], zero[95:90]
    output logic [su2_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [su2_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [su2_pkg::DIM_REG_W-1:0]       i_cfg_data
);

    logic [su2_pkg::DIM_REG_W-1:0] r_width, r_height;

    logic              r_a_valid, n_a_valid;
    su2_pkg::t_item    r_a_item;
    logic [1:0]        r_a_k, n_a_k;

    logic              r_o_valid, n_o_valid;
    su2_pkg::t_write   r_o_write;
    logic              r_o_last;

    su2_pkg::t_write    map_write;
    su2_pkg::t_map_stat map_stat;

    logic out_free, emit, a_done, in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= su2_pkg::DIM_RESET;
            r_height <= su2_pkg::DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == su2_pkg::CFG_IN_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_index == su2_pkg::CFG_IN_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    su2_map #(
        .MAX_DIM      (MAX_DIM),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_map (
        .i_item   (r_a_item),
        .i_k      (r_a_k),
        .i_width  (r_width),
        .i_height (r_height),
        .o_write  (map_write),
        .o_stat   (map_stat)
    );

    assign out_free = !r_o_valid || m_axis_tready;
    assign emit     = r_a_valid && !map_stat.drop && out_free;
    // dropped items leave at once, others after their last write
    assign a_done   = r_a_valid && (map_stat.drop || (out_free && map_stat.last));
    assign s_axis_tready = !r_a_valid || a_done;
    assign in_take  = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_a_valid = r_a_valid;
        n_a_k     = r_a_k;
        if (in_take) begin
            n_a_valid = 1'b1;
            n_a_k     = 2'd0;
        end else if (a_done) begin
            n_a_valid = 1'b0;
        end else if (emit) begin
            n_a_k = r_a_k + 2'd1;
        end
        n_o_valid = r_o_valid;
        if (emit) begin
            n_o_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_k     <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_a_k     <= n_a_k;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_item <= su2_pkg::t_item'(s_axis_tdata);
        end
        if (emit) begin
            r_o_write <= map_write;
            r_o_last  <= map_stat.last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {{(su2_pkg::OUT_TDATA_W - $bits(su2_pkg::t_write)){1'b0}}, r_o_write};
    assign m_axis_tlast  = r_o_last;

endmodule

// ----- design/su2_checker.sv -----
module su2_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [su2_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic                                m_axis_tlast
);

    // stalled write request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("write request changed while stalled");

    // the register stages are empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // the remaining writes of a split coefficient follow without a gap
    a_split_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside the writes of one coefficient");

    // writes of one coefficient share its channel
    a_split_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tdata[25:22] == $past(m_axis_tdata[25:22]))
        else $error("channel changed inside the writes of one coefficient");

endmodule

bind spectrum_upsample_by_two su2_checker u_su2_checker (.*);

// ----- tb/sv/tb_spectrum_upsample_by_two.sv -----
`timescale 1ns / 1ps

module tb_spectrum_upsample_by_two;
    import su2_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int NUM_PHASES   = 9;

    typedef struct {
        t_write wr;
        logic   last;
    } t_plane_write;

    class upsample_scoreboard;
        logic [DIM_REG_W-1:0] width_reg;
        logic [DIM_REG_W-1:0] height_reg;
        t_plane_write staged[$];
        t_plane_write pending_writes[$];
        int fails;
        int n_coeffs;
        int n_dropped;
        int n_nyquist;
        int n_writes;

        function new();
            width_reg  = DIM_RESET;
            height_reg = DIM_RESET;
            fails      = 0;
            n_coeffs   = 0;
            n_dropped  = 0;
            n_nyquist  = 0;
            n_writes   = 0;
        endfunction

        function int unsigned clamp_dim(logic [DIM_REG_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
            return 32'(v);
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg);
        endfunction

        function logic [VAL_W-1:0] scaled_value(logic [VAL_W-1:0] v, int gain);
            longint p;
            p = longint'($signed(v)) * gain;
            if (p > 64'sd2147483647) p = 64'sd2147483647;
            if (p < -64'sd2147483648) p = -64'sd2147483648;
            return p[VAL_W-1:0];
        endfunction

        // fills staged with the plane writes of one coefficient, row-major
        function int map_coefficient(t_item it);
            int unsigned w, h, hw, hh, nr, nc, r, c;
            int unsigned rows[2];
            int unsigned cols[2];
            bit nyq_c, nyq_r;
            int gain;
            t_plane_write pw;
            staged.delete();
            w  = eff_width();
            h  = eff_height();
            r  = 32'(it.row);
            c  = 32'(it.col);
            hw = (w + 1) / 2;
            hh = (h + 1) / 2;
            if (r >= h || c >= w || it.chan >= MAX_CHANNELS_DEFAULT) return 0;
            nyq_c = (w % 2 == 0) && (c == hw);
            nyq_r = (h % 2 == 0) && (r == hh);
            if (nyq_c) begin
                cols[0] = hw;
                cols[1] = hw + w;
                nc = 2;
            end else begin
                cols[0] = (c < hw) ? c : c + w;
                nc = 1;
            end
            if (nyq_r) begin
                rows[0] = hh;
                rows[1] = hh + h;
                nr = 2;
            end else begin
                rows[0] = (r < hh) ? r : r + h;
                nr = 1;
            end
            if (nyq_c && nyq_r) gain = 1;
            else if (nyq_c || nyq_r) gain = 2;
            else gain = 4;
            for (int i = 0; i < nr; i++) begin
                for (int j = 0; j < nc; j++) begin
                    pw.wr.row  = rows[i][OUT_IDX_W-1:0];
                    pw.wr.col  = cols[j][OUT_IDX_W-1:0];
                    pw.wr.chan = it.chan;
                    pw.wr.re   = scaled_value(it.re, gain);
                    pw.wr.im   = scaled_value(it.im, gain);
                    pw.last    = 1'b0;
                    staged.push_back(pw);
                end
            end
            staged[staged.size()-1].last = 1'b1;
            return staged.size();
        endfunction

        function void note_coeff(t_item it);
            int n;
            n = map_coefficient(it);
            n_coeffs++;
            if (n == 0) n_dropped++;
            if (n > 1) n_nyquist++;
            foreach (staged[k]) pending_writes.push_back(staged[k]);
        endfunction

        function void check_field(string name, longint e, longint a);
            if (e != a) begin
                $error("%s: expected %0d, actual %0d", name, e, a);
                fails++;
            end
        endfunction

        function void check_write(logic [OUT_TDATA_W-1:0] data, logic last);
            t_plane_write e;
            t_write got;
            got = data[$bits(t_write)-1:0];
            n_writes++;
            if (pending_writes.size() == 0) begin
                $error("plane write (row %0d, col %0d) with no coefficient behind it",
                       got.row, got.col);
                fails++;
                return;
            end
            e = pending_writes.pop_front();
            check_field("out_row", e.wr.row, got.row);
            check_field("out_col", e.wr.col, got.col);
            check_field("out_chan", e.wr.chan, got.chan);
            check_field("out_re", $signed(e.wr.re), $signed(got.re));
            check_field("out_im", $signed(e.wr.im), $signed(got.im));
            check_field("last_write", e.last, last);
            check_field("tdata padding", 0, data[OUT_TDATA_W-1:$bits(t_write)]);
        endfunction

        function void check_drained();
            if (pending_writes.size() != 0) begin
                $error("%0d plane writes never arrived", pending_writes.size());
                fails++;
            end
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [DIM_REG_W-1:0]   i_cfg_data    = '0;

    upsample_scoreboard sb = new();

    int burst_left = 0;
    int rx_left    = 0;
    int rx_mode    = 0;
    int rx_tick    = 0;
    int idle_count = 0;

    spectrum_upsample_by_two dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // handshakes are read in the active region, before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_coeff(t_item'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) sb.check_write(m_axis_tdata, m_axis_tlast);
        end
    end

    // receiver stall pattern: modes held for a stretch of cycles
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_tick % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_REG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IN_WIDTH) sb.width_reg = val;
        else if (idx == CFG_IN_HEIGHT) sb.height_reg = val;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_writes.size() != 0) @(posedge i_clk);
        // dropped coefficients may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_coeff(t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_fields(int r, int c, int ch, logic [31:0] re, logic [31:0] im);
        t_item it;
        it.row  = IN_IDX_W'(r);
        it.col  = IN_IDX_W'(c);
        it.chan = CHAN_W'(ch);
        it.re   = re;
        it.im   = im;
        send_coeff(it);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] edges[8] = '{32'h1FFF_FFFF, 32'h2000_0000, 32'hE000_0000,
                                  32'hDFFF_FFFF, 32'h3FFF_FFFF, 32'h4000_0000,
                                  32'hC000_0000, 32'hBFFF_FFFF};
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return edges[$urandom_range(0, 7)];
            3: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned random_index(int unsigned d);
        case ($urandom_range(0, 7))
            0, 1: return (d % 2 == 0) ? d / 2 : $urandom_range(0, d - 1);
            2: return 0;
            3: return d - 1;
            4: return (d + 1) / 2 - 1;
            default: return $urandom_range(0, d - 1);
        endcase
    endfunction

    function automatic t_item random_coeff();
        t_item it;
        if ($urandom_range(0, 9) == 0) begin
            it.row = IN_IDX_W'($urandom_range(0, 1023));
            it.col = IN_IDX_W'($urandom_range(0, 1023));
        end else begin
            it.row = IN_IDX_W'(random_index(sb.eff_height()));
            it.col = IN_IDX_W'(random_index(sb.eff_width()));
        end
        it.chan = CHAN_W'($urandom_range(0, 15));
        it.re   = random_value();
        it.im   = random_value();
        return it;
    endfunction

    task automatic run_random(int target);
        t_item it;
        int mapped;
        mapped = 0;
        while (mapped < target) begin
            it = random_coeff();
            if (sb.map_coefficient(it) > 0) mapped++;
            send_coeff(it);
        end
    endtask

    // square planes at 256 and 1024, then the degenerate and odd/even mixes
    logic [DIM_REG_W-1:0] phase_w[NUM_PHASES] = '{11'd256, 11'd1024, 11'd2, 11'd0, 11'd7,
                                                  11'd2047, 11'd1, 11'd1500, 11'd5};
    logic [DIM_REG_W-1:0] phase_h[NUM_PHASES] = '{11'd256, 11'd1024, 11'd2, 11'd2047, 11'd6,
                                                  11'd0, 11'd1, 11'd3, 11'd1024};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // phase 0 runs on the reset dimensions
            if (p > 0) begin
                wait_drained();
                write_reg(CFG_IN_WIDTH, phase_w[p]);
                write_reg(CFG_IN_HEIGHT, phase_h[p]);
                if (phase_w[p] == 11'd7) begin
                    // spare indexes must leave both dimensions alone
                    write_reg(CFG_SPARE_A, 11'h7FF);
                    write_reg(CFG_SPARE_B, 11'h000);
                end
            end
            if (p == 1) begin
                send_fields(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
                send_fields(1023, 1023, 15, 32'h8000_0000, 32'h7FFF_FFFF);
                send_fields(511, 511, 3, 32'h0000_0000, 32'hFFFF_FFFF);
                send_fields(513, 513, 4, 32'h0000_0001, 32'h0000_0000);
                send_fields(512, 0, 1, 32'h1234_5678, 32'hF000_0001);
                send_fields(0, 512, 2, 32'hFEDC_BA98, 32'h0FFF_FFFF);
                send_fields(512, 512, 15, 32'h7FFF_FFFF, 32'h8000_0000);
                send_fields(512, 512, 0, 32'h8000_0000, 32'hFFFF_FFFF);
                send_fields(100, 900, 7, 32'h1FFF_FFFF, 32'h2000_0000);
                send_fields(900, 100, 8, 32'hE000_0000, 32'hDFFF_FFFF);
                send_fields(512, 900, 9, 32'h3FFF_FFFF, 32'h4000_0000);
                send_fields(900, 512, 6, 32'hC000_0000, 32'hBFFF_FFFF);
                send_fields(682, 341, 10, 32'h5555_5555, 32'hAAAA_AAAA);
                send_fields(341, 682, 5, 32'hAAAA_AAAA, 32'h5555_5555);
            end
            if (p == 2) begin
                send_fields(1, 1, 11, 32'h7FFF_FFFF, 32'h8000_0000);
                send_fields(1, 0, 12, 32'h4000_0000, 32'hC000_0000);
                send_fields(0, 1, 13, 32'h3FFF_FFFF, 32'hBFFF_FFFF);
                send_fields(0, 0, 14, 32'h0000_0003, 32'hFFFF_FFFD);
                // outside the 2x2 plane: no writes
                send_fields(2, 0, 0, 32'h1111_1111, 32'h2222_2222);
                send_fields(0, 2, 0, 32'h3333_3333, 32'h4444_4444);
                send_fields(1023, 1023, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end
            run_random((p == 0) ? 15 : 20);
        end

        wait_drained();
        sb.check_drained();
        $display("Run covered %0d coefficients (%0d out of range, %0d on Nyquist lines)",
                 sb.n_coeffs, sb.n_dropped, sb.n_nyquist);
        $display("giving %0d plane writes over %0d dimension settings from 1x1 to 1024x1024",
                 sb.n_writes, NUM_PHASES);
        if (sb.fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
